/* hdl/irl_pkg.sv */
// shared types, register indexes and microcode table for the ir range filter and linearizer
`timescale 1ns / 1ps
package irl_pkg;

  // field and register widths
  localparam int unsigned SampleW = 10;
  localparam int unsigned DistW   = 20;
  localparam int unsigned CoefW   = 52;
  localparam int unsigned StageW  = 26;
  localparam int unsigned AlphaW  = 16;
  localparam int unsigned ThrW    = 10;
  localparam int unsigned ClampW  = 11;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 52;
  localparam int unsigned NumCoef = 5;

  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  // configuration register indexes
  localparam cfg_idx_t CFG_ALPHA     = 3'd0;
  localparam cfg_idx_t CFG_LOW_THR   = 3'd1;
  localparam cfg_idx_t CFG_CLAMP     = 3'd2;
  localparam cfg_idx_t CFG_COEF_X4   = 3'd3;
  localparam cfg_idx_t CFG_COEF_X3   = 3'd4;
  localparam cfg_idx_t CFG_COEF_X2   = 3'd5;
  localparam cfg_idx_t CFG_COEF_X1   = 3'd6;
  localparam cfg_idx_t CFG_COEF_X0   = 3'd7;

  // multiplier operand selects
  typedef enum logic [1:0] {
    MA_ALPHA,
    MA_NALPHA,
    MA_MAG_LO,
    MA_MAG_HI
  } mul_a_e;

  typedef enum logic [1:0] {
    MB_XIN,
    MB_FS,
    MB_SS
  } mul_b_e;

  typedef enum logic [1:0] {
    SUM_HOLD,
    SUM_PROD,
    SUM_RND
  } sum_op_e;

  typedef enum logic [1:0] {
    ST_HOLD,
    ST_FS_EMA,
    ST_SS_EMA,
    ST_PRIME
  } st_op_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_COEF4,
    ACC_STEP
  } acc_op_e;

  typedef enum logic [1:0] {
    OUT_NONE,
    OUT_DIST,
    OUT_CLAMP
  } out_op_e;

  typedef enum logic [2:0] {
    J_NEXT,
    J_WAIT_IN,
    J_PRIME,
    J_CLAMP,
    J_LOOP,
    J_EMIT,
    J_GOTO
  } jmp_e;

  typedef logic [3:0] step_t;

  // program addresses
  localparam step_t S_FETCH   = 4'd0;
  localparam step_t S_EMA1_A  = 4'd1;
  localparam step_t S_EMA1_B  = 4'd2;
  localparam step_t S_EMA1_W  = 4'd3;
  localparam step_t S_EMA2_A  = 4'd4;
  localparam step_t S_EMA2_B  = 4'd5;
  localparam step_t S_EMA2_W  = 4'd6;
  localparam step_t S_TEST    = 4'd7;
  localparam step_t S_HN_MAG  = 4'd8;
  localparam step_t S_HN_LO   = 4'd9;
  localparam step_t S_HN_HI   = 4'd10;
  localparam step_t S_HN_Q    = 4'd11;
  localparam step_t S_HN_ACC  = 4'd12;
  localparam step_t S_OUT     = 4'd13;
  localparam step_t S_CLAMP   = 4'd14;
  localparam step_t S_PRIME   = 4'd15;

  localparam logic [1:0] LOOP_LAST = 2'd3;

  typedef struct packed {
    mul_a_e  mul_a;
    mul_b_e  mul_b;
    sum_op_e sum_op;
    st_op_e  st_op;
    acc_op_e acc_op;
    logic    mag_ld;
    logic    q_ld;
    out_op_e out_op;
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    jmp_e   jmp;
    step_t  tgt;
  } cw_t;

  // sequencer to datapath
  typedef struct packed {
    dp_op_t     op;
    logic       take;
    logic [1:0] k;
  } ctl_t;

  // datapath to sequencer
  typedef struct packed {
    logic in_valid;
    logic prime;
    logic clamp;
    logic out_free;
  } stat_t;

  localparam dp_op_t OP_NOP = '{
    mul_a: MA_ALPHA, mul_b: MB_XIN, sum_op: SUM_HOLD, st_op: ST_HOLD,
    acc_op: ACC_HOLD, mag_ld: 1'b0, q_ld: 1'b0, out_op: OUT_NONE
  };

  // microcode rom
  function automatic cw_t irl_rom(input step_t addr);
    cw_t w;
    w = '{op: OP_NOP, jmp: J_NEXT, tgt: S_FETCH};
    unique case (addr)
      S_FETCH: begin
        w.jmp = J_WAIT_IN;
      end
      S_EMA1_A: begin
        w.op.mul_a = MA_ALPHA;
        w.op.mul_b = MB_XIN;
        w.jmp      = J_PRIME;
        w.tgt      = S_PRIME;
      end
      S_EMA1_B: begin
        w.op.mul_a  = MA_NALPHA;
        w.op.mul_b  = MB_FS;
        w.op.sum_op = SUM_PROD;
      end
      S_EMA1_W: begin
        w.op.st_op = ST_FS_EMA;
      end
      S_EMA2_A: begin
        w.op.mul_a = MA_ALPHA;
        w.op.mul_b = MB_FS;
      end
      S_EMA2_B: begin
        w.op.mul_a  = MA_NALPHA;
        w.op.mul_b  = MB_SS;
        w.op.sum_op = SUM_PROD;
      end
      S_EMA2_W: begin
        w.op.st_op = ST_SS_EMA;
      end
      S_TEST: begin
        w.op.acc_op = ACC_COEF4;
        w.jmp       = J_CLAMP;
        w.tgt       = S_CLAMP;
      end
      S_HN_MAG: begin
        w.op.mag_ld = 1'b1;
      end
      S_HN_LO: begin
        w.op.mul_a = MA_MAG_LO;
        w.op.mul_b = MB_SS;
      end
      S_HN_HI: begin
        w.op.mul_a  = MA_MAG_HI;
        w.op.mul_b  = MB_SS;
        w.op.sum_op = SUM_RND;
      end
      S_HN_Q: begin
        w.op.q_ld = 1'b1;
      end
      S_HN_ACC: begin
        w.op.acc_op = ACC_STEP;
        w.jmp       = J_LOOP;
        w.tgt       = S_HN_MAG;
      end
      S_OUT: begin
        w.op.out_op = OUT_DIST;
        w.jmp       = J_EMIT;
        w.tgt       = S_FETCH;
      end
      S_CLAMP: begin
        w.op.out_op = OUT_CLAMP;
        w.jmp       = J_EMIT;
        w.tgt       = S_FETCH;
      end
      S_PRIME: begin
        w.op.st_op = ST_PRIME;
        w.jmp      = J_GOTO;
        w.tgt      = S_FETCH;
      end
    endcase
    return w;
  endfunction

endpackage

/* hdl/irl_if.sv */
// request channel interfaces for samples in and distances out
`timescale 1ns / 1ps
interface irl_in_if;
  logic                      valid;
  logic                      ready;
  logic [irl_pkg::SampleW-1:0] sample;
  logic                      prime;

  modport source (output valid, output sample, output prime, input ready);
  modport sink   (input valid, input sample, input prime, output ready);
endinterface

interface irl_out_if;
  logic                            valid;
  logic                            ready;
  logic signed [irl_pkg::DistW-1:0] distance;

  modport source (output valid, output distance, input ready);
  modport sink   (input valid, input distance, output ready);
endinterface

/* hdl/irl_seq.sv */
// microcode sequencer: step counter, rom fetch, loop counter and conditional jumps
`timescale 1ns / 1ps
module irl_seq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  irl_pkg::stat_t stat_i,
  output irl_pkg::ctl_t  ctl_o,
  output logic           in_ready_o
);
  import irl_pkg::*;

  step_t      step_q, step_d;
  logic [1:0] k_q, k_d;
  cw_t        cw;
  logic       stall;

  assign cw    = irl_rom(step_q);
  assign stall = (cw.jmp == J_EMIT) && !stat_i.out_free;

  always_comb begin
    step_d = step_q + 4'd1;
    k_d    = k_q;
    unique case (cw.jmp)
      J_NEXT:    step_d = step_q + 4'd1;
      J_WAIT_IN: step_d = stat_i.in_valid ? step_q + 4'd1 : step_q;
      J_PRIME:   step_d = stat_i.prime ? cw.tgt : step_q + 4'd1;
      J_CLAMP: begin
        step_d = stat_i.clamp ? cw.tgt : step_q + 4'd1;
        k_d    = 2'd0;
      end
      J_LOOP: begin
        if (k_q == LOOP_LAST) begin
          step_d = step_q + 4'd1;
          k_d    = 2'd0;
        end else begin
          step_d = cw.tgt;
          k_d    = k_q + 2'd1;
        end
      end
      J_EMIT:    step_d = stall ? step_q : cw.tgt;
      J_GOTO:    step_d = cw.tgt;
      default:   step_d = S_FETCH;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= S_FETCH;
      k_q    <= 2'd0;
    end else begin
      step_q <= step_d;
      k_q    <= k_d;
    end
  end

  always_comb begin
    ctl_o    = '{op: cw.op, take: 1'b0, k: k_q};
    ctl_o.take = (cw.jmp == J_WAIT_IN) && stat_i.in_valid;
    if (stall) begin
      ctl_o.op.out_op = OUT_NONE;
    end
  end

  assign in_ready_o = (cw.jmp == J_WAIT_IN);

  // an accepted request always starts the filter program
  a_take_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.take |=> step_q == S_EMA1_A)
    else $error("accepted request did not start the program");

  // loop counter is only in use inside the polynomial loop
  a_k_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q < S_HN_MAG || step_q > S_HN_ACC) |-> k_q == 2'd0)
    else $error("loop counter live outside the polynomial loop");

  // a blocked result holds the program where it is
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall |=> $stable(step_q))
    else $error("step advanced while result was blocked");

  // no request is taken while a result step is pending
  a_ready_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (step_q == S_FETCH && ctl_o.op.out_op == OUT_NONE))
    else $error("input ready outside the fetch step");

endmodule

/* hdl/irl_dp.sv */
// datapath: config registers, filter stages, shared multiplier, horner accumulator, output register
`timescale 1ns / 1ps
module irl_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  irl_pkg::cfg_idx_t             cfg_idx_i,
  input  logic [irl_pkg::CfgW-1:0]      cfg_data_i,
  input  logic                          in_valid_i,
  input  logic [irl_pkg::SampleW-1:0]   in_sample_i,
  input  logic                          in_prime_i,
  input  irl_pkg::ctl_t                 ctl_i,
  input  logic                          out_ready_i,
  output irl_pkg::stat_t                stat_o,
  output logic                          out_valid_o,
  output logic signed [irl_pkg::DistW-1:0] out_distance_o
);
  import irl_pkg::*;

  localparam logic signed [55:0] SatHi  = 56'sd2251799813685247;
  localparam logic signed [55:0] SatLo  = -56'sd2251799813685248;
  localparam logic [62:0]        QLim   = 63'd1 << 53;
  localparam logic signed [20:0] DistHi = 21'sd524287;
  localparam logic signed [20:0] DistLo = -21'sd524288;

  // configuration
  logic [AlphaW-1:0]       alpha_q;
  logic [ThrW-1:0]         thr_q;
  logic [ClampW-1:0]       clamp_q;
  logic signed [CoefW-1:0] coef_q [NumCoef];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q   <= 16'd19661;
      thr_q     <= 10'd66;
      clamp_q   <= 11'd150;
      coef_q[0] <= 52'sd9187;
      coef_q[1] <= -52'sd14755446;
      coef_q[2] <= 52'sd8667560112;
      coef_q[3] <= -52'sd2322036220000;
      coef_q[4] <= 52'sd283062816600000;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ALPHA:   alpha_q   <= cfg_data_i[AlphaW-1:0];
        CFG_LOW_THR: thr_q     <= cfg_data_i[ThrW-1:0];
        CFG_CLAMP:   clamp_q   <= cfg_data_i[ClampW-1:0];
        CFG_COEF_X4: coef_q[0] <= cfg_data_i;
        CFG_COEF_X3: coef_q[1] <= cfg_data_i;
        CFG_COEF_X2: coef_q[2] <= cfg_data_i;
        CFG_COEF_X1: coef_q[3] <= cfg_data_i;
        CFG_COEF_X0: coef_q[4] <= cfg_data_i;
      endcase
    end
  end

  // working registers
  logic [SampleW-1:0]      sample_q;
  logic                    prime_q;
  logic [StageW-1:0]       fs_q, ss_q;
  logic [57:0]             prod_q, sum_q;
  logic signed [CoefW-1:0] acc_q;
  logic [CoefW-1:0]        mag_q;
  logic                    neg_q;
  logic [53:0]             q_q;
  logic signed [DistW-1:0] dist_q;
  logic                    out_valid_q;

  logic [31:0]             mul_a;
  logic [StageW-1:0]       mul_b;
  logic [16:0]             nalpha;
  logic [StageW-1:0]       xin;
  logic [58:0]             ema_sum;
  logic [58:0]             rnd_sum;
  logic [62:0]             q_sum;
  logic [2:0]              cidx;
  logic signed [55:0]      c_ext, q_ext, s_sum;
  logic signed [CoefW-1:0] s_sat;
  logic signed [52:0]      out_t;
  logic signed [20:0]      out_d;
  logic signed [DistW-1:0] dist_sat;

  assign nalpha = 17'h10000 - {1'b0, alpha_q};
  assign xin    = {sample_q, 16'b0};

  always_comb begin
    unique case (ctl_i.op.mul_a)
      MA_ALPHA:  mul_a = {16'b0, alpha_q};
      MA_NALPHA: mul_a = {15'b0, nalpha};
      MA_MAG_LO: mul_a = mag_q[31:0];
      MA_MAG_HI: mul_a = {12'b0, mag_q[51:32]};
      default:   mul_a = '0;
    endcase
    unique case (ctl_i.op.mul_b)
      MB_XIN:  mul_b = xin;
      MB_FS:   mul_b = fs_q;
      MB_SS:   mul_b = ss_q;
      default: mul_b = '0;
    endcase
  end

  // rounded filter update and rounded partial product
  assign ema_sum = {1'b0, sum_q} + {1'b0, prod_q} + 59'd32768;
  assign rnd_sum = {1'b0, prod_q} + (neg_q ? 59'd32767 : 59'd32768);
  assign q_sum   = {prod_q[46:0], 16'b0} + {20'b0, sum_q[42:0]};

  // horner add with saturation
  assign cidx  = {1'b0, ctl_i.k} + 3'd1;
  assign c_ext = {{4{coef_q[cidx][CoefW-1]}}, coef_q[cidx]};
  assign q_ext = {2'b0, q_q};
  assign s_sum = neg_q ? (c_ext - q_ext) : (c_ext + q_ext);

  always_comb begin
    if (s_sum > SatHi) begin
      s_sat = SatHi[CoefW-1:0];
    end else if (s_sum < SatLo) begin
      s_sat = SatLo[CoefW-1:0];
    end else begin
      s_sat = s_sum[CoefW-1:0];
    end
  end

  // final rounding to q11.8
  assign out_t = {acc_q[CoefW-1], acc_q} + 53'sd2147483648;
  assign out_d = out_t[52:32];

  always_comb begin
    if (out_d > DistHi) begin
      dist_sat = DistHi[DistW-1:0];
    end else if (out_d < DistLo) begin
      dist_sat = DistLo[DistW-1:0];
    end else begin
      dist_sat = out_d[DistW-1:0];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    prod_q <= 58'(mul_a) * 58'(mul_b);
    if (ctl_i.take) begin
      sample_q <= in_sample_i;
      prime_q  <= in_prime_i;
    end
    unique case (ctl_i.op.sum_op)
      SUM_PROD: sum_q <= prod_q;
      SUM_RND:  sum_q <= {15'b0, rnd_sum[58:16]};
      default:  sum_q <= sum_q;
    endcase
    unique case (ctl_i.op.acc_op)
      ACC_COEF4: acc_q <= coef_q[0];
      ACC_STEP:  acc_q <= s_sat;
      default:   acc_q <= acc_q;
    endcase
    if (ctl_i.op.mag_ld) begin
      mag_q <= acc_q[CoefW-1] ? (52'd0 - acc_q) : acc_q;
      neg_q <= acc_q[CoefW-1];
    end
    if (ctl_i.op.q_ld) begin
      q_q <= (q_sum > QLim) ? QLim[53:0] : q_sum[53:0];
    end
    unique case (ctl_i.op.out_op)
      OUT_DIST:  dist_q <= dist_sat;
      OUT_CLAMP: dist_q <= {1'b0, clamp_q, 8'b0};
      default:   dist_q <= dist_q;
    endcase
  end

  // filter state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fs_q        <= '0;
      ss_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      unique case (ctl_i.op.st_op)
        ST_FS_EMA: fs_q <= ema_sum[41:16];
        ST_SS_EMA: ss_q <= ema_sum[41:16];
        ST_PRIME: begin
          fs_q <= xin;
          ss_q <= xin;
        end
        default: ;
      endcase
      if (ctl_i.op.out_op != OUT_NONE) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o = '{
    in_valid: in_valid_i,
    prime:    prime_q,
    clamp:    (ss_q < {thr_q, 16'b0}),
    out_free: (!out_valid_q || out_ready_i)
  };

  assign out_valid_o    = out_valid_q;
  assign out_distance_o = dist_q;

endmodule

/* hdl/ir_range_filter_linearizer.sv */
// top level of the ir range filter and linearizer
`timescale 1ns / 1ps
// ir range filter and linearizer
// - in_if carries one 10-bit sample and a prime flag per request; ready is high
//   only while the sequencer sits at its fetch step
// - out_if carries one signed q11.8 distance per non-prime request, in order
// - cfg_we_i/cfg_idx_i/cfg_data_i write one register per cycle: alpha, low
//   threshold, clamp distance, then the five coefficients x4 down to x0
// - one 32x26 multiplier serves both filter updates and the four horner
//   steps (two partial products each)
// - result is registered into the output register at its final step;
//   it sits there while the receiver stalls and the next request is
//   still accepted; a second result waits in its step until the register
//   frees up
// - reset clears both filter stages, loads the register defaults and leaves
//   the output empty; no clearing pass is needed
module ir_range_filter_linearizer (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  irl_pkg::cfg_idx_t        cfg_idx_i,
  input  logic [irl_pkg::CfgW-1:0] cfg_data_i,
  irl_in_if.sink                   in_if,
  irl_out_if.source                out_if
);
  import irl_pkg::*;

  ctl_t  ctl;
  stat_t stat;
  logic  in_ready;

  // control program
  irl_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .stat_i     (stat),
    .ctl_o      (ctl),
    .in_ready_o (in_ready)
  );

  // arithmetic and storage
  irl_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_if.valid),
    .in_sample_i    (in_if.sample),
    .in_prime_i     (in_if.prime),
    .ctl_i          (ctl),
    .out_ready_i    (out_if.ready),
    .stat_o         (stat),
    .out_valid_o    (out_if.valid),
    .out_distance_o (out_if.distance)
  );

  assign in_if.ready = in_ready;

endmodule
